[design/b64_pkg.sv]
package b64_pkg;

   localparam logic [7:0] PAD_CHAR = 8'd61;
   localparam int         GRP_MAX  = 4;
   localparam int         CNT_W    = $clog2(GRP_MAX + 1);
   localparam int         IDX_W    = $clog2(GRP_MAX);
   localparam int         HELD_W   = 18;
   localparam int         ADDR_W   = 3;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } b64_mode_type;

   typedef enum logic {
      REG_MODE  = 1'b0,
      REG_SPARE = 1'b1
   } b64_reg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       bad;
   } b64_rsp_type;

   typedef struct packed {
      logic                    load;
      logic [CNT_W-1:0]        count;
      b64_rsp_type [GRP_MAX-1:0] entry;
   } b64_grp_type;

   typedef struct packed {
      b64_mode_type mode;
      logic         clear;
   } b64_ctl_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } b64_sextet_type;

   function automatic logic [7:0] enc_char(input logic [5:0] s);
      logic [7:0] c;
      if (s < 6'd26) begin
         c = 8'd65 + {2'b00, s};
      end else if (s < 6'd52) begin
         c = 8'd71 + {2'b00, s};
      end else if (s < 6'd62) begin
         c = {2'b00, s} - 8'd4;
      end else if (s == 6'd62) begin
         c = 8'd43;
      end else begin
         c = 8'd47;
      end
      return c;
   endfunction

   function automatic b64_sextet_type dec_sextet(input logic [7:0] c);
      b64_sextet_type r;
      r.valid = 1'b1;
      r.value = 6'd0;
      if (c >= 8'd65 && c <= 8'd90) begin
         r.value = 6'(c - 8'd65);
      end else if (c >= 8'd97 && c <= 8'd122) begin
         r.value = 6'(c - 8'd71);
      end else if (c >= 8'd48 && c <= 8'd57) begin
         r.value = 6'(c + 8'd4);
      end else if (c == 8'd43) begin
         r.value = 6'd62;
      end else if (c == 8'd47) begin
         r.value = 6'd63;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

[design/b64_csr.sv]
module b64_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [b64_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output b64_pkg::b64_ctl_type       ctl
);
   import b64_pkg::*;

   b64_mode_type mode_ff, mode_in;
   logic         wr_mode;
   b64_reg_type  reg_sel;

   assign reg_sel    = b64_reg_type'(csr_paddr[ADDR_W-1]);
   assign csr_pready = 1'b1;
   assign wr_mode    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_sel == REG_MODE);

   always_comb begin
      mode_in = mode_ff;
      if (wr_mode) begin
         mode_in = b64_mode_type'(csr_pwdata[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MODE:  csr_prdata = {31'd0, mode_ff};
         REG_SPARE: csr_prdata = 32'd0;
         default:   csr_prdata = 32'd0;
      endcase
   end

   assign ctl.mode  = mode_ff;
   assign ctl.clear = wr_mode;

endmodule

[design/b64_core.sv]
module b64_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_in_last,
   input  b64_pkg::b64_ctl_type ctl,
   input  logic                 buf_free,
   output b64_pkg::b64_grp_type grp
);
   import b64_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic              third_pad_ff, third_pad_in;
   logic              err_ff, err_in;
   logic              accept, consume;
   logic [CNT_W-1:0]  n;
   b64_rsp_type [GRP_MAX-1:0] ent;

   always_comb begin
      logic [23:0]    triple;
      logic [2:0]     nreal;
      b64_sextet_type sx;
      logic           pad, err_n, w1, w2;
      logic [5:0]     val;

      phase_in     = phase_ff;
      held_in      = held_ff;
      third_pad_in = third_pad_ff;
      err_in       = err_ff;
      n            = '0;
      ent          = '0;
      triple       = '0;
      nreal        = '0;
      sx           = dec_sextet(in_byte_ff);
      pad          = (in_byte_ff == PAD_CHAR);
      val          = sx.valid ? sx.value : 6'd0;
      err_n        = err_ff || !(sx.valid || (phase_ff >= 2'd2 && pad));
      w1           = !third_pad_ff;
      w2           = !pad;

      unique case (ctl.mode)
         MODE_ENCODE: begin
            if (phase_ff < 2'd2 && !in_last_ff) begin
               held_in  = {held_ff[HELD_W-9:0], in_byte_ff};
               phase_in = phase_ff + 2'd1;
            end else begin
               unique case (phase_ff)
                  2'd0:    triple = {in_byte_ff, 16'h0000};
                  2'd1:    triple = {held_ff[7:0], in_byte_ff, 8'h00};
                  default: triple = {held_ff[15:0], in_byte_ff};
               endcase
               nreal = (phase_ff >= 2'd2) ? 3'd4 : {1'b0, phase_ff} + 3'd2;
               for (int i = 0; i < GRP_MAX; i++) begin
                  ent[i].data = (3'(i) < nreal) ? enc_char(triple[23-6*i -: 6])
                                                : PAD_CHAR;
               end
               n            = CNT_W'(GRP_MAX);
               phase_in     = '0;
               held_in      = '0;
               third_pad_in = 1'b0;
               err_in       = 1'b0;
            end
         end
         MODE_DECODE: begin
            if (phase_ff < 2'd3) begin
               if (phase_ff == 2'd2) begin
                  third_pad_in = pad;
               end
               held_in  = {held_ff[HELD_W-7:0], val};
               phase_in = phase_ff + 2'd1;
               err_in   = err_n;
               if (in_last_ff) begin
                  n            = CNT_W'(1);
                  ent[0].bad   = 1'b1;
                  phase_in     = '0;
                  held_in      = '0;
                  third_pad_in = 1'b0;
                  err_in       = 1'b0;
               end
            end else begin
               triple       = {held_ff, val};
               phase_in     = '0;
               held_in      = '0;
               third_pad_in = 1'b0;
               if (err_n) begin
                  err_in = !in_last_ff;
                  if (in_last_ff) begin
                     n          = CNT_W'(1);
                     ent[0].bad = 1'b1;
                  end
               end else begin
                  err_in      = 1'b0;
                  ent[0].data = triple[23:16];
                  ent[1].data = w1 ? triple[15:8] : triple[7:0];
                  ent[2].data = triple[7:0];
                  n           = CNT_W'(1) + CNT_W'(w1) + CNT_W'(w2);
               end
            end
         end
         default: begin
            n = '0;
         end
      endcase

      for (int k = 0; k < GRP_MAX; k++) begin
         ent[k].last = in_last_ff && (CNT_W'(k) + CNT_W'(1) == n);
      end
   end

   assign consume     = in_valid_ff && ((n == '0) || buf_free);
   assign req_stall   = in_valid_ff && !consume;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !consume);

   assign grp.load  = consume && (n != '0);
   assign grp.count = n;
   assign grp.entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= '0;
         held_ff      <= '0;
         third_pad_ff <= 1'b0;
         err_ff       <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (ctl.clear) begin
            phase_ff     <= '0;
            held_ff      <= '0;
            third_pad_ff <= 1'b0;
            err_ff       <= 1'b0;
         end else if (consume) begin
            phase_ff     <= phase_in;
            held_ff      <= held_in;
            third_pad_ff <= third_pad_in;
            err_ff       <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

endmodule

[design/b64_rspq.sv]
module b64_rspq (
   input  logic                 clock,
   input  logic                 reset,
   input  b64_pkg::b64_grp_type grp,
   output logic                 buf_free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_last,
   output logic                 rsp_bad_input
);
   import b64_pkg::*;

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [IDX_W-1:0]          rd_ff, rd_in;
   b64_rsp_type [GRP_MAX-1:0] ent_ff;
   logic                      take;

   assign rsp_valid     = (cnt_ff != '0);
   assign take          = rsp_valid && !rsp_stall;
   assign buf_free      = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && take);
   assign rsp_out_byte  = ent_ff[rd_ff].data;
   assign rsp_out_last  = ent_ff[rd_ff].last;
   assign rsp_bad_input = ent_ff[rd_ff].bad;

   always_comb begin
      cnt_in = cnt_ff;
      rd_in  = rd_ff;
      priority if (grp.load) begin
         cnt_in = grp.count;
         rd_in  = '0;
      end else if (take) begin
         cnt_in = cnt_ff - CNT_W'(1);
         rd_in  = rd_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp.load) begin
         ent_ff <= grp.entry;
      end
   end

endmodule

[design/base64_codec_top.sv]
// Base64 stream codec, standard alphabet.
// Input channel req_*: one byte per transaction, req_in_last on the final
// byte of a message. Result channel rsp_*: one byte per transaction,
// rsp_out_last on the final result, rsp_bad_input on the single error
// result of a failed decode. Register mode at csr address 0 selects encode
// (0) or decode (1); writing it aborts any partial group. Write it only
// while no transaction is in flight.
// A transaction is registered at the input and, once the four-entry result
// buffer is free, the results it yields are written into that buffer, from
// which they are presented in order.
// Throughput: while rsp_stall is low the result port drains one byte per
// cycle, so encoding is limited by the four characters each group of three
// input bytes yields; decoding sustains one character per cycle. Items that
// give no result pass at one per cycle even while the buffer drains.
// Reset clears mode to encode, the group state and both channel registers.
// A stalled receiver holds the current result; the input register passes on
// items that give no result, then req_stall rises until the buffer drains.
module base64_codec_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_in_byte,
   input  logic                       req_in_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_out_last,
   output logic                       rsp_bad_input,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [b64_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import b64_pkg::*;

   b64_ctl_type ctl;
   b64_grp_type grp;
   logic        buf_free;

   b64_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ctl         (ctl)
   );

   b64_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .ctl         (ctl),
      .buf_free    (buf_free),
      .grp         (grp)
   );

   b64_rspq u_rspq (
      .clock         (clock),
      .reset         (reset),
      .grp           (grp),
      .buf_free      (buf_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .rsp_bad_input (rsp_bad_input)
   );

endmodule

[design/b64_checker.sv]
module b64_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       rsp_bad_input
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_last) && $stable(rsp_bad_input))
      else $error("stalled result transaction changed");

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_input |-> rsp_out_last && (rsp_out_byte == 8'd0))
      else $error("error result not a zero final transaction");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with result buffer empty");

endmodule

bind base64_codec_top b64_checker u_b64_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_out_last  (rsp_out_last),
   .rsp_bad_input (rsp_bad_input)
);
